// ----- design/ida_pkg.sv -----
// Shared constants and helpers for the integer to decimal ASCII converter.
`timescale 1ns / 1ps
`default_nettype none
package ida_pkg;

  localparam logic [7:0] DIGIT_BASE = 8'd48;
  localparam logic [7:0] MINUS_CHAR = 8'd45;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

  // decimal digits needed for an unsigned magnitude of the given bit count
  function automatic int dec_digits(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

endpackage
`default_nettype wire

// ----- design/ida_front.sv -----
// Front end: takes a value, forms sign and magnitude, runs shift-add-3 to BCD.
`timescale 1ns / 1ps
`default_nettype none
module ida_front #(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output logic                       push_valid_o,
  input  wire logic                  push_ready_i,
  output logic [4*NDIG:0]            push_data_o   // {neg, bcd digits}
);
  import ida_pkg::*;

  localparam int CntW = $clog2(VALUE_BITS + 1);
  localparam logic [CntW-1:0] StepCount = CntW'(VALUE_BITS);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [4*NDIG-1:0]     bcd_q, bcd_d;
  logic                  neg_q, neg_d;
  logic [4*NDIG-1:0]     bcd_adj;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;

  assign in_neg = value_i[VALUE_BITS-1];
  // the most negative value wraps to itself, which as unsigned is its magnitude
  assign in_mag = in_neg ? (~value_i + VALUE_BITS'(1)) : value_i;

  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_q[4*d +: 4] >= BCD_ADJ_MIN) begin
        bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + BCD_ADJ_ADD;
      end else begin
        bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          bin_d   = in_mag;
          bcd_d   = '0;
          neg_d   = in_neg;
          cnt_d   = StepCount;
          state_d = F_CONV;
        end
      end
      F_CONV: begin
        {bcd_d, bin_d} = {bcd_adj[4*NDIG-2:0], bin_q, 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign in_ready_o   = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_data_o  = {neg_q, bcd_q};

endmodule
`default_nettype wire

// ----- design/ida_fifo.sv -----
// Two-entry queue between the converter and the character emitter.
`timescale 1ns / 1ps
`default_nettype none
module ida_fifo #(
  parameter int WIDTH = 41
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output logic [WIDTH-1:0]      rd_data_o
);
  import ida_pkg::*;

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd) rd_ptr_q <= ~rd_ptr_q;
      if (do_wr && !do_rd) begin
        count_q <= count_q + 2'd1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule
`default_nettype wire

// ----- design/ida_back.sv -----
// Back end: skips leading zeros and emits sign and digits one word per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none
module ida_back #(
  parameter int NDIG = 10
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            pop_valid_i,
  output logic                 pop_ready_o,
  input  wire logic [4*NDIG:0] pop_data_i,   // {neg, bcd digits}
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_char_o,
  output logic                 out_last_o
);
  import ida_pkg::*;

  localparam int IdxW = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam logic [IdxW-1:0] TopIdx = IdxW'(NDIG - 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SKIP = 2'd1;
  localparam logic [1:0] B_SIGN = 2'd2;
  localparam logic [1:0] B_EMIT = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [4*NDIG-1:0] bcd_q, bcd_d;
  logic              neg_q, neg_d;
  logic              ovalid_q, ovalid_d;
  logic [7:0]        ochar_q, ochar_d;
  logic              olast_q, olast_d;
  logic              slot_free;
  logic [3:0]        cur_digit;

  assign slot_free = !ovalid_q || out_ready_i;
  assign cur_digit = bcd_q[4*idx_q +: 4];

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    bcd_d    = bcd_q;
    neg_d    = neg_q;
    ovalid_d = ovalid_q && !out_ready_i;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          neg_d   = pop_data_i[4*NDIG];
          bcd_d   = pop_data_i[4*NDIG-1:0];
          idx_d   = TopIdx;
          state_d = B_SKIP;
        end
      end
      B_SKIP: begin
        // zero keeps its lowest digit
        if (cur_digit == 4'd0 && idx_q != '0) begin
          idx_d = idx_q - IdxW'(1);
        end else begin
          state_d = neg_q ? B_SIGN : B_EMIT;
        end
      end
      B_SIGN: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ochar_d  = MINUS_CHAR;
          olast_d  = 1'b0;
          state_d  = B_EMIT;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ochar_d  = DIGIT_BASE + {4'd0, cur_digit};
          olast_d  = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = B_IDLE;
          end else begin
            idx_d = idx_q - IdxW'(1);
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q   <= bcd_d;
    neg_q   <= neg_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign pop_ready_o = (state_q == B_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

endmodule
`default_nettype wire

// ----- design/int_to_decimal_ascii.sv -----
// Top level: signed integer to decimal ASCII text converter.
//
// Input stream: one signed VALUE_BITS integer per word on s_axis_tdata_i.
// Output stream: one ASCII character per word, '-' first for negative
// values, then the decimal digits most significant first without leading
// zeros; zero gives "0". tlast marks the final character of each number.
// Front end: a value is taken when idle, then VALUE_BITS shift-add-3 steps
// run one per cycle, and the BCD result goes into a two-entry queue, so the
// front end takes a new value only after the last one is in the queue, and
// waits to push while the queue is full. Back end: takes an entry, skips
// leading zeros one digit at a time, then emits the characters (sign plus
// digits) one per cycle while the receiver is ready, and takes no new entry
// until the last character of the value is loaded. For 32 bits the
// sustained rate is bounded by the shift-add-3 loop, not by the back end,
// while the receiver does not stall.
// The output word sits in a register; a new character loads in the cycle
// it is taken. While the receiver stalls, the back end holds, the queue
// fills and then the front end stops accepting.
// Reset empties the queue and returns both ends to idle; no word is pending.
`timescale 1ns / 1ps
`default_nettype none
module int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata_i,  // [VALUE_BITS-1:0] value
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic [7:0]                             m_axis_tdata_o,  // [7:0] ascii_char
  output logic                                   m_axis_tlast_o
);
  import ida_pkg::*;

  localparam int NDIG  = dec_digits(VALUE_BITS);
  localparam int EntryW = 4 * NDIG + 1;

  logic              push_valid, push_ready;
  logic [EntryW-1:0] push_data;
  logic              pop_valid, pop_ready;
  logic [EntryW-1:0] pop_data;

  ida_front #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .value_i     (s_axis_tdata_i[VALUE_BITS-1:0]),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  ida_fifo #(
    .WIDTH(EntryW)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(push_valid),
    .wr_ready_o(push_ready),
    .wr_data_i (push_data),
    .rd_valid_o(pop_valid),
    .rd_ready_i(pop_ready),
    .rd_data_o (pop_data)
  );

  ida_back #(
    .NDIG(NDIG)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_char_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

// ----- design/ida_checker.sv -----
// Port-level checks for the decimal text converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ida_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic       m_axis_tlast_o
);
  import ida_pkg::*;

  // every character is a minus sign or a decimal digit
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o == MINUS_CHAR) ||
      ((m_axis_tdata_o >= DIGIT_BASE) && (m_axis_tdata_o <= DIGIT_BASE + 8'd9)))
    else $error("output word is not a sign or digit");

  // a minus sign never ends a number
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o == MINUS_CHAR) |-> !m_axis_tlast_o)
    else $error("minus sign flagged as last");

  // a taken minus sign is followed by a nonzero leading digit, not another sign
  a_after_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tdata_o == MINUS_CHAR) |=>
      (!m_axis_tvalid_o || (m_axis_tdata_o != MINUS_CHAR && m_axis_tdata_o != DIGIT_BASE)))
    else $error("bad character after minus sign");

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("output word changed while stalled");

endmodule

bind int_to_decimal_ascii ida_checker u_ida_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);
`default_nettype wire
